### hdl/quadrature_encoder_with_button_core_macros.svh
// Assertion macros for the quadrature encoder with button core.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef QUADRATURE_ENCODER_WITH_BUTTON_CORE_MACROS_SVH
`define QUADRATURE_ENCODER_WITH_BUTTON_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define QEBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("qebc check failed: same-cycle implication");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define QEBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("qebc check failed: next-cycle implication");
`else
`define QEBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define QEBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/qebc_pkg.sv
// Shared types, codes and the quadrature step table for the encoder core.
// Used by the rotary, button and top-level modules; depends on nothing.
package qebc_pkg;

	// Direction codes reported with each result beat.
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_CW   = 2'd1;
	localparam logic [1:0] DIR_CCW  = 2'd2;

	// Sticky click report codes.
	localparam logic [1:0] CLICK_NONE  = 2'd0;
	localparam logic [1:0] CLICK_SHORT = 2'd1;
	localparam logic [1:0] CLICK_LONG  = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic CFG_DEBOUNCE   = 1'b0;
	localparam logic CFG_LONG_CLICK = 1'b1;
	localparam logic [31:0] DEBOUNCE_RST   = 32'd5000;
	localparam logic [31:0] LONG_CLICK_RST = 32'd1000000;

	// Stream widths: fields packed from bit 0 up, padded to whole bytes.
	localparam int IN_BITS  = 35;
	localparam int OUT_BITS = 37;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [31:0] now_us;
		logic        button_level;
		logic        pin_b;
		logic        pin_a;
	} poll_t;

	typedef struct packed {
		logic [31:0] position;
		logic        step_evt;
		logic [1:0]  direction;
	} rot_res_t;

	typedef struct packed {
		logic [1:0] click_kind;
		logic       click_evt;
	} btn_res_t;

	// Step from the previous AB state to the new one: -1, 0 or +1.
	// A double step, both bits changing, counts as no step.
	function automatic logic signed [1:0] step_lut(input logic [1:0] prev_ab,
		input logic [1:0] new_ab);
		logic signed [1:0] s;
		unique case ({prev_ab, new_ab})
			4'b0001, 4'b0111, 4'b1000, 4'b1110: s = 2'sd1;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: s = -2'sd1;
			default:                            s = 2'sd0;
		endcase
		return s;
	endfunction

endpackage

### hdl/quadrature_encoder_with_button_core.sv
// Quadrature encoder with push button: takes one poll beat (pins A and B, button
// level, microsecond time) per clock and returns one result beat per poll with the
// detent position, an event flag, the direction and a sticky click report. A poll
// enters an input register, passes the step table, phase accumulator and button
// timers combinationally, and lands in the result register, which presents the
// result beat; a new poll is taken every cycle while the result side keeps up.
// While a result waits, one more poll can enter the input register; after that
// the poll side stalls until the waiting result is taken. Configuration writes
// take effect on the next clock and belong to idle periods.
`include "quadrature_encoder_with_button_core_macros.svh"
module quadrature_encoder_with_button_core import qebc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [31:0]            cfg_data,
	// Poll stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// Fields from bit 0: pin_a, pin_b, button_level, now_us[31:0], zero pad.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// Result stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// Fields from bit 0: position[31:0], changed, direction[1:0], click_kind[1:0], pad.
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [31:0] debounce_q;
	logic [31:0] long_click_q;

	poll_t    poll_s1;
	logic     valid_s1;
	logic     advance;
	rot_res_t rot_res;
	btn_res_t btn_res;

	logic [31:0] position_q;
	logic        changed_q;
	logic [1:0]  direction_q;
	logic [1:0]  click_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_click_q <= LONG_CLICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:   debounce_q   <= cfg_data;
				CFG_LONG_CLICK: long_click_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// The poll in the input register moves on when the result register is free.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			poll_s1 <= s_tdata[IN_BITS-1:0];
		end
	end

	qebc_rotary u_rotary (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.pin_a   (poll_s1.pin_a),
		.pin_b   (poll_s1.pin_b),
		.res     (rot_res)
	);

	qebc_button u_button (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.button_level  (poll_s1.button_level),
		.now_us        (poll_s1.now_us),
		.debounce_us   (debounce_q),
		.long_click_us (long_click_q),
		.res           (btn_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			position_q  <= rot_res.position;
			changed_q   <= rot_res.step_evt | btn_res.click_evt;
			direction_q <= rot_res.direction;
			click_q     <= btn_res.click_kind;
		end
	end

	assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
		click_q, direction_q, changed_q, position_q};

	// A reported direction always comes with the event flag.
	`QEBC_ASSERT_IMPLY(a_dir_changed, clk, arst_n, m_tvalid && (direction_q != DIR_NONE), changed_q)
	// A held poll with a stalled result keeps the poll side closed.
	`QEBC_ASSERT_IMPLY(a_stall_blocks, clk, arst_n, valid_s1 && m_tvalid && !m_tready, !s_tready)
	// A poll that leaves the input register shows up as a result beat.
	`QEBC_ASSERT_NEXT(a_advance_out, clk, arst_n, advance, m_tvalid)

endmodule

### hdl/qebc_rotary.sv
// Rotary part of the encoder core: AB state, phase accumulator and detent counter.
// Depends on qebc_pkg for the step table and direction codes.
module qebc_rotary import qebc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  logic     pin_a,
	input  logic     pin_b,
	output rot_res_t res
);

	logic [1:0]        prev_ab_q;
	logic signed [1:0] phase_q;
	logic [31:0]       count_q;

	logic [1:0]        new_ab;
	logic signed [2:0] phase_sum;
	logic signed [1:0] phase_nxt;
	logic [31:0]       count_nxt;

	// Add the step into the phase and move the counter at plus or minus two.
	always_comb begin
		new_ab    = {pin_a, pin_b};
		phase_sum = 3'(phase_q) + 3'(step_lut(prev_ab_q, new_ab));
		phase_nxt = phase_sum[1:0];
		count_nxt = count_q;
		res.step_evt  = 1'b0;
		res.direction = DIR_NONE;
		if (phase_sum == 3'sd2) begin
			count_nxt     = count_q + 32'd1;
			phase_nxt     = 2'sd0;
			res.step_evt  = 1'b1;
			res.direction = DIR_CW;
		end else if (phase_sum == -3'sd2) begin
			count_nxt     = count_q - 32'd1;
			phase_nxt     = 2'sd0;
			res.step_evt  = 1'b1;
			res.direction = DIR_CCW;
		end
		res.position = count_nxt;
	end

	// State moves only when the poll leaves for the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q <= 2'b00;
			phase_q   <= 2'sd0;
			count_q   <= 32'd0;
		end else if (advance) begin
			prev_ab_q <= new_ab;
			phase_q   <= phase_nxt;
			count_q   <= count_nxt;
		end
	end

endmodule

### hdl/qebc_button.sv
// Button part of the encoder core: press tracking, long-click and debounced click.
// Depends on qebc_pkg for the click codes.
module qebc_button import qebc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        button_level,
	input  logic [31:0] now_us,
	input  logic [31:0] debounce_us,
	input  logic [31:0] long_click_us,
	output btn_res_t    res
);

	logic        pressed_q;
	logic [31:0] press_start_q;
	logic        long_done_q;
	logic [31:0] last_release_q;
	logic [1:0]  click_q;

	logic        pressed_nxt;
	logic [31:0] press_start_nxt;
	logic        long_done_nxt;
	logic [31:0] last_release_nxt;
	logic [1:0]  click_nxt;
	logic [31:0] held_time;
	logic [31:0] since_release;

	// Press, hold and release decisions; time differences wrap modulo 2^32.
	always_comb begin
		pressed_nxt      = pressed_q;
		press_start_nxt  = press_start_q;
		long_done_nxt    = long_done_q;
		last_release_nxt = last_release_q;
		click_nxt        = click_q;
		res.click_evt    = 1'b0;
		since_release    = now_us - last_release_q;
		if (!button_level) begin
			// A new press starts its hold timer at this poll.
			if (!pressed_q) begin
				pressed_nxt     = 1'b1;
				press_start_nxt = now_us;
				long_done_nxt   = 1'b0;
			end
			held_time = now_us - press_start_nxt;
			if (!long_done_nxt && held_time > long_click_us) begin
				click_nxt     = CLICK_LONG;
				res.click_evt = 1'b1;
				long_done_nxt = 1'b1;
			end
		end else begin
			held_time = now_us - press_start_q;
			if (pressed_q && since_release > debounce_us) begin
				last_release_nxt = now_us;
				if (held_time <= long_click_us) begin
					click_nxt     = CLICK_SHORT;
					res.click_evt = 1'b1;
				end
				pressed_nxt = 1'b0;
			end else begin
				click_nxt = CLICK_NONE;
			end
		end
		res.click_kind = click_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q      <= 1'b0;
			press_start_q  <= 32'd0;
			long_done_q    <= 1'b0;
			last_release_q <= 32'd0;
			click_q        <= CLICK_NONE;
		end else if (advance) begin
			pressed_q      <= pressed_nxt;
			press_start_q  <= press_start_nxt;
			long_done_q    <= long_done_nxt;
			last_release_q <= last_release_nxt;
			click_q        <= click_nxt;
		end
	end

endmodule

### tb/quadrature_encoder_with_button_core_tb.sv
// Self-checking testbench for the quadrature encoder with button core: directed
// rotation and click sequences, then random traffic under several timing settings.
// Depends on qebc_pkg and the core RTL only.
module quadrature_encoder_with_button_core_tb import qebc_pkg::*;;

	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_POLLS = 140;

	// Expected result beat, packed in the same order as m_tdata.
	typedef struct packed {
		logic [1:0]  click_kind;
		logic [1:0]  direction;
		logic        changed;
		logic [31:0] position;
	} report_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = CFG_DEBOUNCE;
	logic [31:0]            cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// Fields from bit 0: pin_a, pin_b, button_level, now_us[31:0], zero pad.
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// Fields from bit 0: position[31:0], changed, direction[1:0], click_kind[1:0], pad.
	logic [OUT_TDATA_W-1:0] m_tdata;

	quadrature_encoder_with_button_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Predicted decoder state, mirrored from the reset values of the core.
	logic [31:0] debounce_lim = DEBOUNCE_RST;
	logic [31:0] long_lim = LONG_CLICK_RST;
	logic [1:0]  last_ab = 2'b00;
	int          phase_sum = 0;
	logic [31:0] detents = '0;
	logic        held_flag = 1'b0;
	logic [31:0] press_t = '0;
	logic        long_seen = 1'b0;
	logic [31:0] release_t = '0;
	logic [1:0]  click_now = CLICK_NONE;

	report_t expected_q[$];
	int      polls_sent = 0;
	int      beats_checked = 0;
	int      fail_count = 0;
	int      settings_used = 0;
	int      steps_seen = 0;
	int      shorts_seen = 0;
	int      longs_seen = 0;
	int      quiet_cycles = 0;
	logic    valid_burst = 1'b0;
	logic    ready_burst = 1'b0;
	report_t got_beat;
	report_t want_beat;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gray code rank of an AB state; the mapping is its own inverse.
	function automatic logic [1:0] gray_swap(input logic [1:0] v);
		return {v[1], v[1] ^ v[0]};
	endfunction

	// Advances the predicted state by one poll and returns the expected beat.
	function automatic report_t predict_report(input poll_t p);
		report_t     r;
		logic [1:0]  new_ab;
		logic [1:0]  turn;
		logic [31:0] held_for;
		logic [31:0] since_release;
		new_ab = {p.pin_a, p.pin_b};
		turn = gray_swap(new_ab) - gray_swap(last_ab);
		r = '0;
		// One quarter step forward or back along the Gray sequence; two is no step.
		if (turn == 2'd1)
			phase_sum++;
		else if (turn == 2'd3)
			phase_sum--;
		if (phase_sum >= 2) begin
			detents = detents + 32'd1;
			r.changed = 1'b1;
			r.direction = DIR_CW;
			phase_sum = 0;
			steps_seen++;
		end else if (phase_sum <= -2) begin
			detents = detents - 32'd1;
			r.changed = 1'b1;
			r.direction = DIR_CCW;
			phase_sum = 0;
			steps_seen++;
		end
		last_ab = new_ab;
		// Button timing, all differences modulo 2^32.
		if (!p.button_level) begin
			if (!held_flag) begin
				held_flag = 1'b1;
				press_t = p.now_us;
				long_seen = 1'b0;
			end
			held_for = p.now_us - press_t;
			if (!long_seen && held_for > long_lim) begin
				click_now = CLICK_LONG;
				r.changed = 1'b1;
				long_seen = 1'b1;
				longs_seen++;
			end
		end else begin
			since_release = p.now_us - release_t;
			held_for = p.now_us - press_t;
			if (held_flag && since_release > debounce_lim) begin
				release_t = p.now_us;
				if (held_for <= long_lim) begin
					click_now = CLICK_SHORT;
					r.changed = 1'b1;
					shorts_seen++;
				end
				held_flag = 1'b0;
			end else begin
				click_now = CLICK_NONE;
			end
		end
		r.position = detents;
		r.click_kind = click_now;
		return r;
	endfunction

	// Offers one poll beat, records its prediction and then, outside bursts, idles a random while.
	task automatic send_poll(input logic a, input logic b, input logic btn,
		input logic [31:0] now);
		poll_t p;
		int    gap;
		p.pin_a = a;
		p.pin_b = b;
		p.button_level = btn;
		p.now_us = now;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, p};
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(predict_report(p));
		polls_sent++;
		if ($urandom_range(0, 31) == 0)
			valid_burst = !valid_burst;
		gap = valid_burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering polls and lets every outstanding result drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both timing registers on consecutive clocks.
	task automatic write_timing(input logic [31:0] debounce, input logic [31:0] hold_limit);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEBOUNCE;
		cfg_data <= debounce;
		@(posedge clk);
		cfg_index <= CFG_LONG_CLICK;
		cfg_data <= hold_limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		debounce_lim = debounce;
		long_lim = hold_limit;
		settings_used++;
	endtask

	// Full detents both ways, wrap below zero, double steps and time extremes.
	task automatic test_rotation_directed();
		send_poll(1'b0, 1'b1, 1'b1, 32'h0000_0000);
		send_poll(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_poll(1'b1, 1'b0, 1'b1, 32'h0000_0000);
		send_poll(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
		send_poll(1'b1, 1'b0, 1'b1, 32'h5555_5555);
		send_poll(1'b1, 1'b1, 1'b1, 32'hAAAA_AAAA);
		send_poll(1'b0, 1'b1, 1'b1, 32'h0000_0001);
		send_poll(1'b0, 1'b0, 1'b1, 32'h8000_0000);
		send_poll(1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF);
		send_poll(1'b1, 1'b1, 1'b1, 32'h0000_0000);
		send_poll(1'b0, 1'b0, 1'b1, 32'h0000_0000);
		send_poll(1'b1, 1'b1, 1'b1, 32'h0000_0000);
		send_poll(1'b1, 1'b0, 1'b1, 32'h0000_0000);
		send_poll(1'b1, 1'b1, 1'b1, 32'h0000_0000);
		send_poll(1'b0, 1'b1, 1'b1, 32'h0000_0000);
	endtask

	// Long click, release after a long hold, short click across the time wrap,
	// and a release rejected by the debounce window while the press stays pending.
	task automatic test_button_directed();
		send_poll(1'b0, 1'b1, 1'b0, 32'd100);
		send_poll(1'b0, 1'b1, 1'b0, 32'd1000100);
		send_poll(1'b0, 1'b1, 1'b0, 32'd1000101);
		send_poll(1'b0, 1'b1, 1'b0, 32'd2000000);
		send_poll(1'b0, 1'b1, 1'b1, 32'd2000100);
		send_poll(1'b0, 1'b1, 1'b1, 32'd2000200);
		send_poll(1'b0, 1'b1, 1'b0, 32'hFFFF_FF00);
		send_poll(1'b0, 1'b1, 1'b1, 32'h0000_0100);
		send_poll(1'b0, 1'b1, 1'b0, 32'h0000_0200);
		send_poll(1'b0, 1'b1, 1'b1, 32'h0000_0300);
		send_poll(1'b0, 1'b1, 1'b1, 32'h0000_0100 + 32'd5001);
	endtask

	// Random knob turning and button presses under one timing setting.
	task automatic test_random_traffic(input logic [31:0] debounce,
		input logic [31:0] hold_limit, input int tick_max);
		logic [1:0]  rank;
		logic [1:0]  spin;
		logic [1:0]  ab;
		logic        btn;
		logic        bounce;
		logic [31:0] now;
		int          hold_left;
		int          pick;
		settle();
		write_timing(debounce, hold_limit);
		rank = gray_swap(last_ab);
		spin = $urandom_range(0, 1) ? 2'd1 : 2'd3;
		btn = 1'b1;
		hold_left = 0;
		now = $urandom;
		for (int i = 0; i < PHASE_POLLS; i++) begin
			// Mostly clean quarter steps in one direction, with reversals and noise.
			pick = $urandom_range(0, 99);
			if (pick < 70)
				rank = rank + spin;
			else if (pick < 80)
				spin = 2'd0 - spin;
			else if (pick < 85)
				rank = rank + 2'd2;
			else if (pick < 90)
				rank = 2'($urandom_range(0, 3));
			ab = gray_swap(rank);
			// Button held or released in runs, with an occasional one-poll bounce.
			if (hold_left == 0) begin
				btn = !btn;
				hold_left = $urandom_range(1, 10);
			end else begin
				hold_left--;
			end
			bounce = ($urandom_range(0, 19) == 0);
			if ($urandom_range(0, 49) == 0)
				now = $urandom;
			else
				now = now + $urandom_range(0, tick_max);
			send_poll(ab[1], ab[0], btn ^ bounce, now);
		end
	endtask

	// Result side: random stalls per beat, with stretches of steady readiness.
	initial begin : result_sink
		int stall;
		forever begin
			stall = ready_burst ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 31) == 0)
				ready_burst = !ready_burst;
		end
	end

	// Compare every accepted result beat with the oldest prediction.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_beat = m_tdata[OUT_BITS-1:0];
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("ERROR: result beat with nothing expected: %h", m_tdata);
			end else begin
				want_beat = expected_q.pop_front();
				beats_checked++;
				if (got_beat.position !== want_beat.position ||
					got_beat.changed !== want_beat.changed ||
					got_beat.direction !== want_beat.direction ||
					got_beat.click_kind !== want_beat.click_kind) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"ERROR: beat %0d: position %h/%h changed %b/%b",
							" dir %0d/%0d click %0d/%0d (exp/got)"},
							beats_checked, want_beat.position, got_beat.position,
							want_beat.changed, got_beat.changed,
							want_beat.direction, got_beat.direction,
							want_beat.click_kind, got_beat.click_kind);
				end
			end
		end
	end

	// Ends the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rotation_directed();
		test_button_directed();
		test_random_traffic(DEBOUNCE_RST, LONG_CLICK_RST, 400000);
		test_random_traffic(32'd0, 32'd0, 3);
		test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1000);
		test_random_traffic($urandom_range(0, 40), $urandom_range(10, 120), 25);
		test_random_traffic(32'd0, 32'hFFFF_FFFF, 20);
		test_random_traffic(32'hFFFF_FFFF, 32'd0, 3);
		settle();
		$display("Checked %0d result beats from %0d polls under %0d timing settings.",
			beats_checked, polls_sent, settings_used);
		$display("Predicted %0d detent steps, %0d short clicks and %0d long clicks.",
			steps_seen, shorts_seen, longs_seen);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
